/* hw/rtl/lpg_pkg.sv */
// lpg_pkg: shared types, constants and tables of the lissajous point generator
`default_nettype none

package lpg_pkg;

  // angle, time and table dimensions
  localparam int TURN_FRACTION_BITS = 12;
  localparam int SINE_TABLE_DEPTH   = 1024;
  localparam int SWEEP_TURNS        = 2;

  localparam int TFB      = TURN_FRACTION_BITS;
  localparam int QUARTER  = 1 << (TFB - 2);
  localparam int IDX_W    = $clog2(SINE_TABLE_DEPTH);
  localparam int TIME_W   = 14;
  localparam int END_W    = TIME_W + 1;
  localparam int MULT_W   = 4;
  localparam int AMP_W    = 6;
  localparam int SINE_W   = 15;
  localparam int PROD_W   = AMP_W + SINE_W;
  localparam int POS_W    = 8;

  localparam int FREE_STEP  = 16;
  localparam int SWEEP_STEP = 20;
  localparam int ROT_STEP   = 33;

  // register reset values
  localparam logic [6:0]       X_ORIGIN_RST  = 7'd64;
  localparam logic [5:0]       Y_ORIGIN_RST  = 6'd32;
  localparam logic [AMP_W-1:0] AMPLITUDE_RST = 6'd30;
  localparam logic [MULT_W-1:0] MULT_RST     = 4'd1;

  // register indexes
  typedef enum logic [2:0] {
    REG_X_ORIGIN  = 3'd0,
    REG_Y_ORIGIN  = 3'd1,
    REG_AMPLITUDE = 3'd2,
    REG_X_MULT    = 3'd3,
    REG_Y_MULT    = 3'd4,
    REG_X_PHASE   = 3'd5,
    REG_Y_PHASE   = 3'd6,
    REG_MODE      = 3'd7
  } reg_idx_t;

  // register file contents
  typedef struct packed {
    logic [6:0]        x_origin;
    logic [5:0]        y_origin;
    logic [AMP_W-1:0]  amplitude;
    logic [MULT_W-1:0] x_mult;
    logic [MULT_W-1:0] y_mult;
    logic [TFB-1:0]    x_phase;
    logic [TFB-1:0]    y_phase;
    logic              mode;
  } cfg_t;

  // controller states
  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOKUP_Y,
    S_SCALE_Y,
    S_PLACE
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic start;
    logic lookup_y;
    logic scale_y;
    logic load_out;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_busy;
  } ctrl_stat_t;

  typedef logic [SINE_W-1:0] sine_rom_t [SINE_TABLE_DEPTH];
  typedef logic [END_W-1:0]  sweep_tbl_t [1 << MULT_W];

  // q2.30 product truncated toward zero
  function automatic longint mul_q30(longint a, longint b);
    longint p;
    p = a * b;
    if (p < 0) begin
      return -((-p) >>> 30);
    end
    return p >>> 30;
  endfunction

  // quarter-wave sine table from a ninth-order odd polynomial
  function automatic sine_rom_t build_sine_rom();
    sine_rom_t tbl;
    longint u, u2, p, s, e;
    for (int i = 0; i < SINE_TABLE_DEPTH; i++) begin
      u  = (longint'(i) <<< 30) / SINE_TABLE_DEPTH;
      u2 = mul_q30(u, u);
      p  = 64'sd172272;
      p  = -64'sd5026995 + mul_q30(p, u2);
      p  = 64'sd85569306 + mul_q30(p, u2);
      p  = -64'sd693598668 + mul_q30(p, u2);
      p  = 64'sd1686629713 + mul_q30(p, u2);
      s  = mul_q30(p, u);
      if (s < 0) begin
        s = 0;
      end
      e = (s * 32768 + (64'sd1 <<< 29)) >>> 30;
      if (e > 32767) begin
        e = 32767;
      end
      tbl[i] = SINE_W'(e);
    end
    return tbl;
  endfunction

  // full sweep in turn units
  localparam longint SWEEP_SPAN = longint'(SWEEP_TURNS) <<< TFB;

  // sweep length capped at the time range
  function automatic logic [END_W-1:0] sweep_cap(longint v);
    if (v > (64'sd1 <<< TIME_W)) begin
      return END_W'(64'sd1 <<< TIME_W);
    end
    return END_W'(v);
  endfunction

  localparam sine_rom_t  SINE_ROM  = build_sine_rom();

  // sweep length per smallest multiplier, zero counted as one
  localparam sweep_tbl_t SWEEP_END = '{
    sweep_cap(SWEEP_SPAN / 1),  sweep_cap(SWEEP_SPAN / 1),  sweep_cap(SWEEP_SPAN / 2),
    sweep_cap(SWEEP_SPAN / 3),  sweep_cap(SWEEP_SPAN / 4),  sweep_cap(SWEEP_SPAN / 5),
    sweep_cap(SWEEP_SPAN / 6),  sweep_cap(SWEEP_SPAN / 7),  sweep_cap(SWEEP_SPAN / 8),
    sweep_cap(SWEEP_SPAN / 9),  sweep_cap(SWEEP_SPAN / 10), sweep_cap(SWEEP_SPAN / 11),
    sweep_cap(SWEEP_SPAN / 12), sweep_cap(SWEEP_SPAN / 13), sweep_cap(SWEEP_SPAN / 14),
    sweep_cap(SWEEP_SPAN / 15)
  };

endpackage

`default_nettype wire

/* hw/rtl/lpg_cfg.sv */
// lpg_cfg: configuration register file of the lissajous point generator
`default_nettype none

module lpg_cfg
  import lpg_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          cfg_we,
  input  wire logic [2:0]    cfg_index,
  input  wire logic [TFB-1:0] cfg_data,
  output cfg_t               cfg
);

  // register writes by index
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.x_origin  <= X_ORIGIN_RST;
      cfg.y_origin  <= Y_ORIGIN_RST;
      cfg.amplitude <= AMPLITUDE_RST;
      cfg.x_mult    <= MULT_RST;
      cfg.y_mult    <= MULT_RST;
      cfg.x_phase   <= '0;
      cfg.y_phase   <= '0;
      cfg.mode      <= 1'b0;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_X_ORIGIN:  cfg.x_origin  <= cfg_data[6:0];
        REG_Y_ORIGIN:  cfg.y_origin  <= cfg_data[5:0];
        REG_AMPLITUDE: cfg.amplitude <= cfg_data[AMP_W-1:0];
        REG_X_MULT:    cfg.x_mult    <= cfg_data[MULT_W-1:0];
        REG_Y_MULT:    cfg.y_mult    <= cfg_data[MULT_W-1:0];
        REG_X_PHASE:   cfg.x_phase   <= cfg_data;
        REG_Y_PHASE:   cfg.y_phase   <= cfg_data;
        REG_MODE:      cfg.mode      <= cfg_data[0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/lpg_ctrl.sv */
// lpg_ctrl: sequencer that steps one point through the datapath
`default_nettype none

module lpg_ctrl
  import lpg_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire ctrl_stat_t stat,
  output ctrl_cmd_t       cmd
);

  state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.start  = 1'b1;
          state_next = S_LOOKUP_Y;
        end
      end
      S_LOOKUP_Y: begin
        cmd.lookup_y = 1'b1;
        state_next   = S_SCALE_Y;
      end
      S_SCALE_Y: begin
        cmd.scale_y = 1'b1;
        state_next  = S_PLACE;
      end
      S_PLACE: begin
        if (!stat.out_busy) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

`default_nettype wire

/* hw/rtl/lpg_datapath.sv */
// lpg_datapath: time state, angle, sine lookup, scaling and output register
`default_nettype none

module lpg_datapath
  import lpg_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire cfg_t       cfg,
  input  wire ctrl_cmd_t  cmd,
  output ctrl_stat_t      stat,
  input  wire logic       restart,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [POS_W-1:0] out_x,
  output logic [POS_W-1:0] out_y,
  output logic            out_last
);

  logic [TIME_W-1:0] time_position;
  logic [TFB-1:0]    rotation_phase;
  logic [TIME_W-1:0] t_cur;
  logic              frame_pend;
  logic [SINE_W-1:0] rom_q;
  logic              full_q;
  logic              neg_q;
  logic [PROD_W-1:0] prod;
  logic              prod_neg;
  logic [POS_W-1:0]  x_res;

  logic [TIME_W-1:0] t_base, t_adj;
  logic [TFB-1:0]    rot_base;
  logic [MULT_W-1:0] mult_min;
  logic [END_W-1:0]  sweep_end;
  logic [END_W-1:0]  t_step;
  logic [MULT_W-1:0] mult_sel;
  logic [TIME_W-1:0] time_sel;
  logic [TFB-1:0]    phase_sel;
  logic [MULT_W+TIME_W-1:0] angle_prod;
  logic [TFB-1:0]    angle;
  logic [TFB-3:0]    quad_r;
  logic [TFB-2:0]    pos;
  logic              full_c;
  logic [31:0]       idx_wide;
  logic [IDX_W-1:0]  idx;
  logic [SINE_W-1:0] mag;
  logic [PROD_W:0]   round_sum;
  logic [POS_W-1:0]  dev;
  logic [POS_W-1:0]  center_sel;
  logic [POS_W-1:0]  placed;

  // time and rotation as seen by this point
  always_comb begin
    t_base    = restart ? '0 : time_position;
    rot_base  = restart ? '0 : rotation_phase;
    mult_min  = (cfg.x_mult < cfg.y_mult) ? cfg.x_mult : cfg.y_mult;
    sweep_end = SWEEP_END[mult_min];
    t_adj     = (cfg.mode && ({1'b0, t_base} >= sweep_end)) ? '0 : t_base;
    t_step    = {1'b0, t_adj} + END_W'(SWEEP_STEP);
  end

  // angle of the axis being looked up: x on start, y afterwards
  always_comb begin
    mult_sel = cmd.start ? cfg.x_mult : cfg.y_mult;
    time_sel = cmd.start ? t_adj : t_cur;
    if (cmd.start) begin
      phase_sel = cfg.mode ? rot_base : cfg.x_phase;
    end else begin
      phase_sel = cfg.mode ? '0 : cfg.y_phase;
    end
    angle_prod = (MULT_W+TIME_W)'(mult_sel) * (MULT_W+TIME_W)'(time_sel);
    angle      = angle_prod[TFB-1:0] + phase_sel;
  end

  // quadrant folding and table index
  always_comb begin
    quad_r = angle[TFB-3:0];
    if (angle[TFB-2]) begin
      pos = (TFB-1)'(QUARTER) - {1'b0, quad_r};
    end else begin
      pos = {1'b0, quad_r};
    end
    full_c   = pos[TFB-2];
    idx_wide = (32'(pos) * 32'(SINE_TABLE_DEPTH)) >> (TFB - 2);
    if (idx_wide >= 32'(SINE_TABLE_DEPTH)) begin
      idx = IDX_W'(SINE_TABLE_DEPTH - 1);
    end else begin
      idx = idx_wide[IDX_W-1:0];
    end
  end

  // deflection rounding and wrapping sum
  always_comb begin
    mag        = full_q ? {SINE_W{1'b1}} : rom_q;
    round_sum  = {1'b0, prod} + (PROD_W+1)'(1 << (SINE_W - 1));
    dev        = POS_W'(round_sum[PROD_W:SINE_W]);
    center_sel = cmd.scale_y ? {1'b0, cfg.x_origin} : {2'b00, cfg.y_origin};
    placed     = prod_neg ? center_sel - dev : center_sel + dev;
  end

  // time and rotation update, once per accepted transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      time_position  <= '0;
      rotation_phase <= '0;
    end else if (cmd.start) begin
      if (!cfg.mode) begin
        time_position  <= t_adj + TIME_W'(FREE_STEP);
        rotation_phase <= rot_base;
      end else if (t_step >= sweep_end) begin
        time_position  <= '0;
        rotation_phase <= rot_base + TFB'(ROT_STEP);
      end else begin
        time_position  <= t_step[TIME_W-1:0];
        rotation_phase <= rot_base;
      end
    end
  end

  // per-point working registers
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      t_cur      <= t_adj;
      frame_pend <= cfg.mode && (t_step >= sweep_end);
    end
    if (cmd.start || cmd.lookup_y) begin
      rom_q  <= SINE_ROM[idx];
      full_q <= full_c;
      neg_q  <= angle[TFB-1];
    end
    if (cmd.lookup_y || cmd.scale_y) begin
      prod     <= PROD_W'(cfg.amplitude) * PROD_W'(mag);
      prod_neg <= neg_q;
    end
    if (cmd.scale_y) begin
      x_res <= placed;
    end
    if (cmd.load_out) begin
      out_x    <= x_res;
      out_y    <= placed;
      out_last <= frame_pend;
    end
  end

  // output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  assign stat.out_busy = out_valid && !out_ready;

  // a result is only loaded into a free output register
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> !(out_valid && !out_ready))
    else $error("result loaded over a waiting result");

  // the last point of a sweep leaves time at zero
  a_frame_time: assert property (@(posedge clk) disable iff (rst)
    cmd.start |=> (!frame_pend || time_position == '0))
    else $error("time not restarted at end of sweep");

  // time and rotation move only on an accepted transaction
  a_state_hold: assert property (@(posedge clk) disable iff (rst)
    !cmd.start |=> ($stable(time_position) && $stable(rotation_phase)))
    else $error("time or rotation changed without a transaction");

endmodule

`default_nettype wire

/* hw/rtl/lissajous_point_generator.sv */
// lissajous_point_generator: top level, one screen point per input transaction
//
//   channel   dir  handshake                      payload
//   s_axis    in   s_axis_tvalid / s_axis_tready   tdata[0] restart
//   m_axis    out  m_axis_tvalid / m_axis_tready   tdata x_pos, y_pos; tlast frame_end
//   cfg       in   cfg_we                          cfg_index, cfg_data
//
// a point is stepped through the accept cycle, which forms the x angle and reads
// the sine table, then y lookup, y scaling and placement; the single table read
// port and the shared amplitude multiplier set this sequence.
// reset is synchronous and needs no clearing pass; the sine table is constant.
// a finished point waits in the output register while the next is accepted;
// placement holds while that register is still full.
`default_nettype none

module lissajous_point_generator
  import lpg_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [0] restart, [7:1] zero
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata,   // [7:0] x_pos, [15:8] y_pos
  output logic             m_axis_tlast,   // frame_end
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [11:0] cfg_data
);

  cfg_t             cfg;
  ctrl_cmd_t        cmd;
  ctrl_stat_t       stat;
  logic [POS_W-1:0] x_pos;
  logic [POS_W-1:0] y_pos;

  // configuration registers
  lpg_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // sequencer
  lpg_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // datapath
  lpg_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cmd       (cmd),
    .stat      (stat),
    .restart   (s_axis_tdata[0]),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_x     (x_pos),
    .out_y     (y_pos),
    .out_last  (m_axis_tlast)
  );

  assign m_axis_tdata = {y_pos, x_pos};

endmodule

`default_nettype wire
